// ===== sv/nshf_pkg.sv =====
// Shared constants, types and the controller state encoding for the
// sentence header filter. Used by every module of the block but the generic RAM; no dependencies.
`default_nettype none
package nshf_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int HEADER_LEN   = 6;
  localparam int HEADER_W     = 8 * HEADER_LEN;
  localparam int SHADOW_LEN   = HEADER_LEN - 1;
  localparam int SHADOW_IDX_W = $clog2(SHADOW_LEN);

  localparam logic [7:0]          START_CHAR   = 8'h24;
  localparam logic [HEADER_W-1:0] HEADER_RESET = 48'h244750474741;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_FIN
  } state_t;

  // Write into the header shadow copy of the first capture bytes.
  typedef struct packed {
    logic                    we;
    logic [SHADOW_IDX_W-1:0] idx;
    logic [7:0]              data;
  } hdr_wr_t;

endpackage
`default_nettype wire

// ===== sv/nshf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
`default_nettype none
module nshf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nshf_hdr_check.sv =====
// Header check: keeps a copy of the first capture bytes and compares them,
// with the incoming sixth byte, against the configured header.
// Depends on nshf_pkg.
`default_nettype none
module nshf_hdr_check (
  input  wire logic                             clk,
  input  wire nshf_pkg::hdr_wr_t                wr,
  input  wire logic [7:0]                       cmp_byte,
  input  wire logic [nshf_pkg::HEADER_W-1:0]    header,
  output logic                                  match
);

  logic [7:0] shadow [nshf_pkg::SHADOW_LEN];

  always_ff @(posedge clk) begin
    if (wr.we && (wr.idx < nshf_pkg::SHADOW_IDX_W'(nshf_pkg::SHADOW_LEN))) begin
      shadow[wr.idx] <= wr.data;
    end
  end

  assign match = ({shadow[0], shadow[1], shadow[2], shadow[3], shadow[4], cmp_byte}
                  == header);

endmodule
`default_nettype wire

// ===== sv/nmea_sentence_header_filter_unit.sv =====
// Sentence header filter top level: capture controller, line store RAM and
// header check. Depends on nshf_pkg, nshf_ram and nshf_hdr_check.
//
// Usage: received bytes enter on in_valid/in_ready/rx_byte, one transfer
// each. A '$' opens a capture; later bytes are appended to the line store.
// At six bytes the capture is compared with the header register (cfg_we and
// cfg_wdata, reset value "$GPGGA") and dropped on a mismatch; a capture
// that reaches BUFFER_DEPTH bytes is dropped too.
// A non-start byte is taken while the controller is idle. A '$' with an
// open capture starts a flush: the stored bytes come out on
// out_valid/out_ready as out_byte, the last with last_of_run set. After the
// '$' transfer the controller enters FLUSH and issues results one per
// cycle while out_ready is high; the line store read port sets this rate.
// in_ready stays low through the FLUSH and FIN states, which last longer
// while the receiver stalls; a flush holds up to 63 bytes. A stalled
// receiver holds the result in the RAM read register and pauses the reads.
// The last result may still wait while new input bytes are taken.
// Reset (rst, synchronous) closes any capture and restores the header.
`default_nettype none
module nmea_sentence_header_filter_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [7:0]                    out_byte,
  output logic                               last_of_run,
  input  wire logic                          cfg_we,
  input  wire logic [nshf_pkg::HEADER_W-1:0] cfg_wdata
);

  localparam int AW = nshf_pkg::ADDR_W;
  localparam int FW = nshf_pkg::FILL_W;

  nshf_pkg::state_t state, state_next;

  logic [nshf_pkg::HEADER_W-1:0] header;
  logic [FW-1:0]                 fill, fill_next;
  logic [AW-1:0]                 rd_idx;
  logic [AW-1:0]                 last_idx;

  logic          accept_in;
  logic          is_start;
  logic          issue;
  logic          match;
  logic [FW-1:0] fill_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  nshf_pkg::hdr_wr_t hdr_wr;

  assign accept_in = in_valid && in_ready;
  assign is_start  = (rx_byte == nshf_pkg::START_CHAR);
  assign issue     = (state == nshf_pkg::ST_FLUSH) && (!out_valid || out_ready);
  assign fill_inc  = fill + FW'(1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      nshf_pkg::ST_IDLE: begin
        if (accept_in && is_start && (fill != '0)) begin
          state_next = nshf_pkg::ST_FLUSH;
        end
      end
      nshf_pkg::ST_FLUSH: begin
        if (issue && (rd_idx == last_idx)) begin
          state_next = nshf_pkg::ST_FIN;
        end
      end
      nshf_pkg::ST_FIN: begin
        state_next = nshf_pkg::ST_IDLE;
      end
      default: state_next = nshf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the controller: input handshake, store and shadow writes
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = nshf_pkg::START_CHAR;
    hdr_wr.we   = 1'b0;
    hdr_wr.idx  = '0;
    hdr_wr.data = nshf_pkg::START_CHAR;
    unique case (state)
      nshf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept_in) begin
          if (is_start) begin
            if (fill == '0) begin
              ram_we    = 1'b1;
              hdr_wr.we = 1'b1;
            end
          end else if (fill != '0) begin
            ram_we      = 1'b1;
            ram_waddr   = fill[AW-1:0];
            ram_wdata   = rx_byte;
            hdr_wr.we   = (fill < FW'(nshf_pkg::SHADOW_LEN));
            hdr_wr.idx  = fill[nshf_pkg::SHADOW_IDX_W-1:0];
            hdr_wr.data = rx_byte;
          end
        end
      end
      nshf_pkg::ST_FLUSH: begin
        in_ready = 1'b0;
      end
      nshf_pkg::ST_FIN: begin
        // store the start byte only after entry 0 has been read out
        ram_we    = 1'b1;
        hdr_wr.we = 1'b1;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (state == nshf_pkg::ST_FIN) begin
      fill_next = FW'(1);
    end else if (accept_in) begin
      if (is_start) begin
        if (fill == '0) begin
          fill_next = FW'(1);
        end
      end else if (fill != '0) begin
        // drop on a full buffer or a header mismatch
        priority if (fill_inc == FW'(nshf_pkg::BUFFER_DEPTH)) begin
          fill_next = '0;
        end else if ((fill_inc == FW'(nshf_pkg::HEADER_LEN)) && !match) begin
          fill_next = '0;
        end else begin
          fill_next = fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nshf_pkg::ST_IDLE;
      fill      <= '0;
      header    <= nshf_pkg::HEADER_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (cfg_we) begin
        header <= cfg_wdata;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == nshf_pkg::ST_IDLE) && (state_next == nshf_pkg::ST_FLUSH)) begin
      rd_idx   <= '0;
      last_idx <= AW'(fill - FW'(1));
    end else if (issue) begin
      rd_idx <= rd_idx + AW'(1);
    end
    if (issue) begin
      last_of_run <= (rd_idx == last_idx);
    end
  end

  nshf_ram #(
    .WIDTH (8),
    .DEPTH (nshf_pkg::BUFFER_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (out_byte)
  );

  nshf_hdr_check u_hdr_check (
    .clk      (clk),
    .wr       (hdr_wr),
    .cmp_byte (rx_byte),
    .header   (header),
    .match    (match)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for nmea_sentence_header_filter_unit: directed byte
// streams, then random sentences under several header settings and idle mixes.
// Depends on nshf_pkg and the RTL of the filter.
`default_nettype none
module testbench;
  import nshf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } line_char_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [7:0]          rx_byte   = 8'h00;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [HEADER_W-1:0] cfg_wdata = '0;
  logic                in_ready;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                last_of_run;

  // Filter model state.
  logic [HEADER_W-1:0] hdr_value = HEADER_RESET;
  logic [7:0]          line_buf [BUFFER_DEPTH];
  int                  line_fill = 0;
  line_char_t          expected_chars [$];
  line_char_t          want;

  int in_idle_pct    = 0;
  int out_stall_pct  = 0;
  int accepted_bytes = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  nmea_sentence_header_filter_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_chars.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Update the model for one accepted byte; return 1 if the byte was not ignored.
  function automatic bit filter_predict(input logic [7:0] b);
    int  n;
    bit  hit;
    if (b == START_CHAR) begin
      n = (line_fill > BUFFER_DEPTH - 1) ? BUFFER_DEPTH - 1 : line_fill;
      for (int k = 0; k < n; k++) begin
        expected_chars.push_back('{data: line_buf[k], last: (k == n - 1)});
      end
      line_buf[0] = b;
      line_fill   = 1;
      return 1'b1;
    end
    if (line_fill == 0) return 1'b0;
    if (line_fill < BUFFER_DEPTH) line_buf[line_fill] = b;
    line_fill++;
    if (line_fill >= BUFFER_DEPTH) begin
      line_fill = 0;
    end else if (line_fill == HEADER_LEN) begin
      hit = 1'b1;
      for (int k = 0; k < HEADER_LEN; k++) begin
        if (line_buf[k] != hdr_value[8*(HEADER_LEN-1-k) +: 8]) hit = 1'b0;
      end
      if (!hit) line_fill = 0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) begin
      $display("mismatch at cycle %0d: %s expected %02h actual %02h", cycle_count,
               field, exp_v, act_v);
    end
  endtask

  // Compare every output transfer with the oldest expected character.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected out_byte", 8'h00, out_byte);
      end else begin
        want = expected_chars.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
        if (last_of_run !== want.last) begin
          report_mismatch("last_of_run", {7'd0, want.last}, {7'd0, last_of_run});
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    void'(filter_predict(b));
    accepted_bytes++;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender until every expected character is out and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_header(input logic [HEADER_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    hdr_value  = v;
  endtask

  // Mostly well-formed sentences; some noise, corrupted or truncated headers.
  task automatic send_sentence();
    int         kind;
    int         bad_pos;
    int         hdr_sent;
    int         body_len;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    end else begin
      bad_pos  = (kind < 23) ? $urandom_range(1, HEADER_LEN - 1) : -1;
      hdr_sent = (kind >= 23 && kind < 31) ? $urandom_range(1, HEADER_LEN - 1) : HEADER_LEN;
      send_byte(START_CHAR);
      for (int k = 1; k < hdr_sent; k++) begin
        b = hdr_value[8*(HEADER_LEN-1-k) +: 8];
        if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
        send_byte(b);
      end
      if (hdr_sent == HEADER_LEN) begin
        body_len = ($urandom_range(9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
        repeat (body_len) begin
          b = 8'($urandom_range(255));
          if (b == START_CHAR) b = ~b;
          send_byte(b);
        end
      end
    end
  endtask

  task automatic run_traffic(input logic [HEADER_W-1:0] hdr, input int in_pct,
                             input int out_pct, input int items, input bit pauses,
                             input int min_results);
    int byte_base;
    int result_base;
    write_header(hdr);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    byte_base     = accepted_bytes;
    result_base   = results_seen;
    while (accepted_bytes - byte_base < items || results_seen - result_base < min_results) begin
      send_sentence();
      if (pauses && $urandom_range(15) == 0) settle();
    end
    // flush the capture still open
    send_byte(START_CHAR);
  endtask

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_byte(8'h00);       // no capture open: dropped
    send_byte(8'hFF);
    send_text("$GPGGA,1");
    send_text("$G");        // flush the matching sentence
    send_text("$");         // short capture still flushed
    send_text("$GPRMC");    // header mismatch: dropped
    send_text("x$");        // nothing open, nothing to flush
  endtask

  task automatic test_reset_header_no_idle();
    run_traffic(HEADER_RESET, 0, 0, 100, 1'b0, 0);
  endtask

  task automatic test_random_header_sender_idle();
    run_traffic({START_CHAR, 40'({$urandom, $urandom})}, 79, 0, 100, 1'b1, 0);
  endtask

  task automatic test_ones_header_receiver_stall();
    run_traffic(48'h24FFFFFFFFFF, 0, 79, 100, 1'b0, 0);
  endtask

  task automatic test_zeros_header_both_idle();
    run_traffic(48'h240000000000, 24, 24, 100, 1'b1, 0);
  endtask

  task automatic test_header_without_start();
    run_traffic('0, 24, 24, 25, 1'b0, 0);
    run_traffic('1, 0, 0, 25, 1'b0, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_reset_header_no_idle();
    test_random_header_sender_idle();
    test_ones_header_receiver_stall();
    test_zeros_header_both_idle();
    test_header_without_start();
    settle();
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
